// ===== design/sqnp_pkg.sv =====
package sqnp_pkg;

	localparam int DATA_W = 32;
	localparam int STAT_W = 2;
	// coefficients held as 4*a_k, a sum of nine 32-bit samples
	localparam int C_W    = 37;
	localparam int PC_W   = 6;

	localparam logic [STAT_W-1:0] ST_FOUND    = 2'd0;
	localparam logic [STAT_W-1:0] ST_SINGULAR = 2'd1;
	localparam logic [STAT_W-1:0] ST_OUTSIDE  = 2'd2;

	// operand sources of the shared multiplier
	localparam logic [4:0] SRC_DX   = 5'd0;
	localparam logic [4:0] SRC_DY   = 5'd1;
	localparam logic [4:0] SRC_XY   = 5'd2;
	localparam logic [4:0] SRC_XX   = 5'd3;
	localparam logic [4:0] SRC_YY   = 5'd4;
	localparam logic [4:0] SRC_XYY  = 5'd5;
	localparam logic [4:0] SRC_XXY  = 5'd6;
	localparam logic [4:0] SRC_XXYY = 5'd7;
	localparam logic [4:0] SRC_C0   = 5'd8;
	localparam logic [4:0] SRC_C1   = 5'd9;
	localparam logic [4:0] SRC_C2   = 5'd10;
	localparam logic [4:0] SRC_C3   = 5'd11;
	localparam logic [4:0] SRC_C4   = 5'd12;
	localparam logic [4:0] SRC_C5   = 5'd13;
	localparam logic [4:0] SRC_C6   = 5'd14;
	localparam logic [4:0] SRC_C7   = 5'd15;
	localparam logic [4:0] SRC_G0   = 5'd16;
	localparam logic [4:0] SRC_G1   = 5'd17;
	localparam logic [4:0] SRC_H0   = 5'd18;
	localparam logic [4:0] SRC_H1   = 5'd19;
	localparam logic [4:0] SRC_H2   = 5'd20;

	// writeback kinds
	localparam logic [2:0] WB_STORE = 3'd0;
	localparam logic [2:0] WB_FIRST = 3'd1;
	localparam logic [2:0] WB_ACC   = 3'd2;
	localparam logic [2:0] WB_LASTQ = 3'd3;
	localparam logic [2:0] WB_LASTR = 3'd4;

	// constant term loaded with the first product of a sum
	localparam logic [2:0] BIAS_NONE = 3'd0;
	localparam logic [2:0] BIAS_2C3  = 3'd1;
	localparam logic [2:0] BIAS_2C4  = 3'd2;
	localparam logic [2:0] BIAS_C5   = 3'd3;
	localparam logic [2:0] BIAS_C6   = 3'd4;
	localparam logic [2:0] BIAS_C7   = 3'd5;
	localparam logic [2:0] BIAS_C8   = 3'd6;

	// writeback destinations
	localparam logic [3:0] DST_XY   = 4'd0;
	localparam logic [3:0] DST_XX   = 4'd1;
	localparam logic [3:0] DST_YY   = 4'd2;
	localparam logic [3:0] DST_XYY  = 4'd3;
	localparam logic [3:0] DST_XXY  = 4'd4;
	localparam logic [3:0] DST_XXYY = 4'd5;
	localparam logic [3:0] DST_H0   = 4'd6;
	localparam logic [3:0] DST_H1   = 4'd7;
	localparam logic [3:0] DST_H2   = 4'd8;
	localparam logic [3:0] DST_G0   = 4'd9;
	localparam logic [3:0] DST_G1   = 4'd10;
	localparam logic [3:0] DST_DET  = 4'd11;
	localparam logic [3:0] DST_NUM0 = 4'd12;
	localparam logic [3:0] DST_NUM1 = 4'd13;
	localparam logic [3:0] DST_G2   = 4'd14;
	localparam logic [3:0] DST_V    = 4'd15;

	// program layout: Newton step, then the final evaluation
	localparam logic [PC_W-1:0] PC_STEP_LAST = 6'd29;
	localparam logic [PC_W-1:0] PC_FIN_FIRST = 6'd30;
	localparam logic [PC_W-1:0] PC_FIN_LAST  = 6'd43;

	typedef struct packed {
		logic [4:0] src_a;
		logic [4:0] src_b;
		logic       rnd;
		logic [1:0] shl;
		logic       neg;
		logic [2:0] wb;
		logic [2:0] bias;
		logic [3:0] dest;
	} uop_t;

	function automatic uop_t mk(input logic [4:0] a, input logic [4:0] b, input logic rnd,
			input logic [1:0] shl, input logic neg, input logic [2:0] wb,
			input logic [2:0] bias, input logic [3:0] dest);
		uop_t u;
		u.src_a = a;
		u.src_b = b;
		u.rnd   = rnd;
		u.shl   = shl;
		u.neg   = neg;
		u.wb    = wb;
		u.bias  = bias;
		u.dest  = dest;
		return u;
	endfunction

	// microcode of the multiply-accumulate sequencer
	function automatic uop_t uop(input logic [PC_W-1:0] pc);
		uop_t u;
		case (pc)
			// monomials of the current offset
			6'd0:  u = mk(SRC_DX, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XY);
			6'd1:  u = mk(SRC_DX, SRC_DX, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XX);
			6'd2:  u = mk(SRC_DY, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_YY);
			6'd3:  u = mk(SRC_XY, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XYY);
			6'd4:  u = mk(SRC_XX, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XXY);
			// Hessian
			6'd5:  u = mk(SRC_C1, SRC_DY, 1'b1, 2'd1, 1'b0, WB_FIRST, BIAS_2C3, DST_H0);
			6'd6:  u = mk(SRC_C0, SRC_YY, 1'b1, 2'd1, 1'b0, WB_LASTQ, BIAS_NONE, DST_H0);
			6'd7:  u = mk(SRC_C2, SRC_DX, 1'b1, 2'd1, 1'b0, WB_FIRST, BIAS_2C4, DST_H2);
			6'd8:  u = mk(SRC_C0, SRC_XX, 1'b1, 2'd1, 1'b0, WB_LASTQ, BIAS_NONE, DST_H2);
			6'd9:  u = mk(SRC_C1, SRC_DX, 1'b1, 2'd1, 1'b0, WB_FIRST, BIAS_C5, DST_H1);
			6'd10: u = mk(SRC_C2, SRC_DY, 1'b1, 2'd1, 1'b0, WB_ACC, BIAS_NONE, DST_H1);
			6'd11: u = mk(SRC_C0, SRC_XY, 1'b1, 2'd2, 1'b0, WB_LASTQ, BIAS_NONE, DST_H1);
			// gradient
			6'd12: u = mk(SRC_C5, SRC_DY, 1'b1, 2'd0, 1'b0, WB_FIRST, BIAS_C6, DST_G0);
			6'd13: u = mk(SRC_C3, SRC_DX, 1'b1, 2'd1, 1'b0, WB_ACC, BIAS_NONE, DST_G0);
			6'd14: u = mk(SRC_C2, SRC_YY, 1'b1, 2'd1, 1'b0, WB_ACC, BIAS_NONE, DST_G0);
			6'd15: u = mk(SRC_C1, SRC_XY, 1'b1, 2'd1, 1'b0, WB_ACC, BIAS_NONE, DST_G0);
			6'd16: u = mk(SRC_C0, SRC_XYY, 1'b1, 2'd1, 1'b0, WB_LASTQ, BIAS_NONE, DST_G0);
			6'd17: u = mk(SRC_C5, SRC_DX, 1'b1, 2'd0, 1'b0, WB_FIRST, BIAS_C7, DST_G1);
			6'd18: u = mk(SRC_C4, SRC_DY, 1'b1, 2'd1, 1'b0, WB_ACC, BIAS_NONE, DST_G1);
			6'd19: u = mk(SRC_C2, SRC_XY, 1'b1, 2'd1, 1'b0, WB_ACC, BIAS_NONE, DST_G1);
			6'd20: u = mk(SRC_C1, SRC_XX, 1'b1, 2'd1, 1'b0, WB_ACC, BIAS_NONE, DST_G1);
			6'd21: u = mk(SRC_C0, SRC_XXY, 1'b1, 2'd1, 1'b0, WB_LASTQ, BIAS_NONE, DST_G1);
			// determinant, numerators, squared gradient (exact products)
			6'd22: u = mk(SRC_H0, SRC_H2, 1'b0, 2'd0, 1'b0, WB_FIRST, BIAS_NONE, DST_DET);
			6'd23: u = mk(SRC_H1, SRC_H1, 1'b0, 2'd0, 1'b1, WB_LASTR, BIAS_NONE, DST_DET);
			6'd24: u = mk(SRC_G0, SRC_H2, 1'b0, 2'd0, 1'b0, WB_FIRST, BIAS_NONE, DST_NUM0);
			6'd25: u = mk(SRC_G1, SRC_H1, 1'b0, 2'd0, 1'b1, WB_LASTR, BIAS_NONE, DST_NUM0);
			6'd26: u = mk(SRC_G1, SRC_H0, 1'b0, 2'd0, 1'b0, WB_FIRST, BIAS_NONE, DST_NUM1);
			6'd27: u = mk(SRC_G0, SRC_H1, 1'b0, 2'd0, 1'b1, WB_LASTR, BIAS_NONE, DST_NUM1);
			6'd28: u = mk(SRC_G0, SRC_G0, 1'b0, 2'd0, 1'b0, WB_FIRST, BIAS_NONE, DST_G2);
			6'd29: u = mk(SRC_G1, SRC_G1, 1'b0, 2'd0, 1'b0, WB_LASTR, BIAS_NONE, DST_G2);
			// final evaluation of the polynomial
			6'd30: u = mk(SRC_DX, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XY);
			6'd31: u = mk(SRC_DX, SRC_DX, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XX);
			6'd32: u = mk(SRC_DY, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_YY);
			6'd33: u = mk(SRC_XY, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XYY);
			6'd34: u = mk(SRC_XX, SRC_DY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XXY);
			6'd35: u = mk(SRC_XX, SRC_YY, 1'b1, 2'd0, 1'b0, WB_STORE, BIAS_NONE, DST_XXYY);
			6'd36: u = mk(SRC_C1, SRC_XXY, 1'b1, 2'd0, 1'b0, WB_FIRST, BIAS_C8, DST_V);
			6'd37: u = mk(SRC_C2, SRC_XYY, 1'b1, 2'd0, 1'b0, WB_ACC, BIAS_NONE, DST_V);
			6'd38: u = mk(SRC_C3, SRC_XX, 1'b1, 2'd0, 1'b0, WB_ACC, BIAS_NONE, DST_V);
			6'd39: u = mk(SRC_C4, SRC_YY, 1'b1, 2'd0, 1'b0, WB_ACC, BIAS_NONE, DST_V);
			6'd40: u = mk(SRC_C5, SRC_XY, 1'b1, 2'd0, 1'b0, WB_ACC, BIAS_NONE, DST_V);
			6'd41: u = mk(SRC_C6, SRC_DX, 1'b1, 2'd0, 1'b0, WB_ACC, BIAS_NONE, DST_V);
			6'd42: u = mk(SRC_C7, SRC_DY, 1'b1, 2'd0, 1'b0, WB_ACC, BIAS_NONE, DST_V);
			6'd43: u = mk(SRC_C0, SRC_XXYY, 1'b1, 2'd0, 1'b0, WB_LASTQ, BIAS_NONE, DST_V);
			default: u = mk(SRC_DX, SRC_DX, 1'b0, 2'd0, 1'b0, WB_ACC, BIAS_NONE, DST_XY);
		endcase
		return u;
	endfunction

endpackage

// ===== design/sqnp_if.sv =====
interface sqnp_in_if;
	import sqnp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sample_nw;
	logic signed [DATA_W-1:0] sample_n;
	logic signed [DATA_W-1:0] sample_ne;
	logic signed [DATA_W-1:0] sample_w;
	logic signed [DATA_W-1:0] sample_c;
	logic signed [DATA_W-1:0] sample_e;
	logic signed [DATA_W-1:0] sample_sw;
	logic signed [DATA_W-1:0] sample_s;
	logic signed [DATA_W-1:0] sample_se;
	logic signed [DATA_W-1:0] pos_x;
	logic signed [DATA_W-1:0] pos_y;
	modport source (output valid, sample_nw, sample_n, sample_ne, sample_w, sample_c,
		sample_e, sample_sw, sample_s, sample_se, pos_x, pos_y, input ready);
	modport sink (input valid, sample_nw, sample_n, sample_ne, sample_w, sample_c,
		sample_e, sample_sw, sample_s, sample_se, pos_x, pos_y, output ready);
endinterface

interface sqnp_out_if;
	import sqnp_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] new_x;
	logic signed [DATA_W-1:0] new_y;
	logic signed [DATA_W-1:0] peak_value;
	logic [STAT_W-1:0]        status;
	modport source (output valid, new_x, new_y, peak_value, status, input ready);
	modport sink (input valid, new_x, new_y, peak_value, status, output ready);
endinterface

interface sqnp_cfg_if;
	import sqnp_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ===== design/subpixel_quartic_newton_peak.sv =====
// Channel | Dir | Payload                                      | Request taken when
// cfg     | in  | data: grad_tolerance                         | cfg.valid && cfg.ready
// win     | in  | sample_nw..sample_se, pos_x, pos_y           | win.valid && win.ready
// res     | out | new_x, new_y, peak_value, status             | res.valid && res.ready
//
// One request at a time. A Newton step makes 30 multiplier issues, a writeback slot, a
// check and two bit-serial divisions of FRAC_BITS+3 quotient bits each (a division is
// skipped when its quotient saturates); the final evaluation makes 14 issues more.
// The shared 36x32 multiplier and the one-bit-per-cycle divider set the run time.
// arst_n clears control state and sets grad_tolerance to 1; cfg is always ready.
// win is ready only while idle; a held result stalls the block until res is taken.
module subpixel_quartic_newton_peak #(
	parameter int MAX_STEPS = 20,
	parameter int FRAC_BITS = 16
) (
	input logic      clk,
	input logic      arst_n,
	sqnp_cfg_if.sink cfg,
	sqnp_in_if.sink  win,
	sqnp_out_if.source res
);
	import sqnp_pkg::*;

	localparam int W_MONO = FRAC_BITS + 6;
	localparam int W_OFF  = FRAC_BITS + 3;
	localparam int W_UPD  = FRAC_BITS + 5;
	localparam int W_QUO  = FRAC_BITS + 3;
	localparam int W_CNT  = $clog2(W_QUO);
	localparam int W_STEP = $clog2(MAX_STEPS + 1);
	localparam int W_TOL  = DATA_W + FRAC_BITS;

	localparam logic signed [W_OFF-1:0] ONE_Q   = W_OFF'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [W_UPD-1:0] OFF_LIM = W_UPD'(64'sd2 <<< FRAC_BITS);
	localparam logic [W_QUO:0]          STEP_LIM = (W_QUO+1)'(64'd4 << FRAC_BITS);
	localparam logic [67:0]             HALF    = 68'(1) << (FRAC_BITS - 1);
	localparam logic signed [63:0]      LIM31   = 64'sd2147483647;
	localparam logic [63:0] DET_MIN =
		((64'd1 << (2 * FRAC_BITS)) + 64'd99999) / 64'd100000;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_COEF = 4'd1;
	localparam logic [3:0] S_RUN  = 4'd2;
	localparam logic [3:0] S_WAIT = 4'd3;
	localparam logic [3:0] S_CHK  = 4'd4;
	localparam logic [3:0] S_DSET = 4'd5;
	localparam logic [3:0] S_DIV  = 4'd6;
	localparam logic [3:0] S_DUPD = 4'd7;
	localparam logic [3:0] S_RNG  = 4'd8;
	localparam logic [3:0] S_FIN  = 4'd9;
	localparam logic [3:0] S_OUT  = 4'd10;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > LIM31)
			r = LIM31;
		else if (v < -LIM31)
			r = -LIM31;
		return r[DATA_W-1:0];
	endfunction

	// control
	logic [3:0]        state_q;
	logic [PC_W-1:0]   pc_q;
	logic              fin_q;
	logic              vld_s1;
	logic [W_STEP-1:0] steps_q;
	logic              dsel_q;
	logic [W_CNT-1:0]  dcnt_q;
	logic [DATA_W-1:0] tol_q;

	// datapath
	logic signed [DATA_W-1:0] m_q [9];
	logic signed [DATA_W-1:0] px_q, py_q;
	logic signed [C_W-1:0]    c_q [9];
	logic signed [W_OFF-1:0]  dx_q, dy_q;
	logic signed [W_MONO-1:0] xy_q, xx_q, yy_q, xyy_q, xxy_q, xxyy_q;
	logic signed [DATA_W-1:0] g0_q, g1_q, h0_q, h1_q, h2_q, v_q;
	logic signed [63:0]       det_q, num0_q, num1_q, g2_q, acc_q;
	uop_t                     op_s1;
	logic [67:0]              prod_s1;
	logic                     neg_s1;
	logic [65:0]              rem_q;
	logic [63:0]              dvs_q;
	logic [W_QUO-1:0]         quo_q;
	logic                     dneg_q, dsat_q;
	logic signed [DATA_W-1:0] nx_q, ny_q, pk_q;
	logic [STAT_W-1:0]        st_q;

	assign cfg.ready = 1'b1;
	assign win.ready = (state_q == S_IDLE);
	assign res.valid = (state_q == S_OUT);
	assign res.new_x = nx_q;
	assign res.new_y = ny_q;
	assign res.peak_value = pk_q;
	assign res.status = st_q;

	// fit coefficients (times four) from the window
	logic signed [C_W-1:0] me [9];
	logic signed [C_W-1:0] c_n [9];
	always_comb begin
		for (int k = 0; k < 9; k++)
			me[k] = C_W'(m_q[k]);
		c_n[0] = (me[4] <<< 2) - ((me[1] + me[3] + me[5] + me[7]) <<< 1)
			+ (me[0] + me[2] + me[6] + me[8]);
		c_n[1] = ((me[1] - me[7]) <<< 1) - me[0] - me[2] + me[6] + me[8];
		c_n[2] = ((me[3] - me[5]) <<< 1) - me[0] + me[2] - me[6] + me[8];
		c_n[3] = ((me[3] + me[5]) <<< 1) - (me[4] <<< 2);
		c_n[4] = ((me[1] + me[7]) <<< 1) - (me[4] <<< 2);
		c_n[5] = me[0] - me[2] - me[6] + me[8];
		c_n[6] = (me[5] - me[3]) <<< 1;
		c_n[7] = (me[7] - me[1]) <<< 1;
		c_n[8] = me[4] <<< 2;
	end

	// issue stage: operand select and multiply
	uop_t               cur;
	logic signed [63:0] opa, opb;
	logic [63:0]        amag, bmag;
	logic [67:0]        prod_c;
	assign cur = uop(pc_q);

	always_comb begin
		case (cur.src_a)
			SRC_DX:  opa = 64'(dx_q);
			SRC_DY:  opa = 64'(dy_q);
			SRC_XY:  opa = 64'(xy_q);
			SRC_XX:  opa = 64'(xx_q);
			SRC_C0:  opa = 64'(c_q[0]);
			SRC_C1:  opa = 64'(c_q[1]);
			SRC_C2:  opa = 64'(c_q[2]);
			SRC_C3:  opa = 64'(c_q[3]);
			SRC_C4:  opa = 64'(c_q[4]);
			SRC_C5:  opa = 64'(c_q[5]);
			SRC_C6:  opa = 64'(c_q[6]);
			SRC_C7:  opa = 64'(c_q[7]);
			SRC_G0:  opa = 64'(g0_q);
			SRC_G1:  opa = 64'(g1_q);
			SRC_H0:  opa = 64'(h0_q);
			SRC_H1:  opa = 64'(h1_q);
			default: opa = '0;
		endcase
	end

	always_comb begin
		case (cur.src_b)
			SRC_DX:   opb = 64'(dx_q);
			SRC_DY:   opb = 64'(dy_q);
			SRC_XY:   opb = 64'(xy_q);
			SRC_XX:   opb = 64'(xx_q);
			SRC_YY:   opb = 64'(yy_q);
			SRC_XYY:  opb = 64'(xyy_q);
			SRC_XXY:  opb = 64'(xxy_q);
			SRC_XXYY: opb = 64'(xxyy_q);
			SRC_G0:   opb = 64'(g0_q);
			SRC_G1:   opb = 64'(g1_q);
			SRC_H0:   opb = 64'(h0_q);
			SRC_H1:   opb = 64'(h1_q);
			SRC_H2:   opb = 64'(h2_q);
			default:  opb = '0;
		endcase
	end

	assign amag = opa[63] ? 64'(-opa) : 64'(opa);
	assign bmag = opb[63] ? 64'(-opb) : 64'(opb);
	assign prod_c = 68'(amag[35:0]) * 68'(bmag[31:0]);

	// writeback stage: round, sign, scale, accumulate
	logic [67:0]        rnd_full, mag;
	logic signed [63:0] sval, val, bias_v, base, sum;
	logic [63:0]        smag, r2;
	logic signed [63:0] rs2;
	logic signed [DATA_W-1:0] qsum;

	assign rnd_full = (prod_s1 + HALF) >> FRAC_BITS;
	assign mag = op_s1.rnd ? rnd_full : prod_s1;
	assign sval = neg_s1 ? -$signed({1'b0, mag[62:0]}) : $signed({1'b0, mag[62:0]});
	assign val = sval <<< op_s1.shl;

	always_comb begin
		case (op_s1.bias)
			BIAS_2C3: bias_v = 64'(c_q[3]) <<< 1;
			BIAS_2C4: bias_v = 64'(c_q[4]) <<< 1;
			BIAS_C5:  bias_v = 64'(c_q[5]);
			BIAS_C6:  bias_v = 64'(c_q[6]);
			BIAS_C7:  bias_v = 64'(c_q[7]);
			BIAS_C8:  bias_v = 64'(c_q[8]);
			default:  bias_v = '0;
		endcase
	end

	assign base = (op_s1.wb == WB_FIRST) ? bias_v : acc_q;
	assign sum = base + val;
	// divide by four, rounding half away from zero, then saturate
	assign smag = sum[63] ? 64'(-sum) : 64'(sum);
	assign r2 = (smag + 64'd2) >> 2;
	assign rs2 = sum[63] ? -$signed(r2) : $signed(r2);
	assign qsum = sat32(rs2);

	// divider step and increment update
	logic [63:0]        un_c, ud_c, dmag;
	logic [65:0]        rr_c, dt_c;
	logic               ge_c;
	logic [W_QUO:0]     mq_c;
	logic signed [W_UPD-1:0] stepv_c, dold_c, dnew_c, dsat_c;
	logic signed [63:0] num_sel;

	assign num_sel = dsel_q ? num1_q : num0_q;
	assign un_c = num_sel[63] ? 64'(-num_sel) : 64'(num_sel);
	assign ud_c = det_q[63] ? 64'(-det_q) : 64'(det_q);
	assign dmag = ud_c;
	assign rr_c = (dcnt_q >= W_CNT'(2)) ? (rem_q << 1) : rem_q;
	assign dt_c = (dcnt_q == '0) ? (66'(dvs_q) << 1) : 66'(dvs_q);
	assign ge_c = (rr_c >= dt_c);

	always_comb begin
		mq_c = ((W_QUO+1)'(quo_q) + (W_QUO+1)'(1)) >> 1;
		if (dsat_q || mq_c > STEP_LIM)
			mq_c = STEP_LIM;
		stepv_c = dneg_q ? -$signed(W_UPD'(mq_c)) : $signed(W_UPD'(mq_c));
		dold_c = dsel_q ? W_UPD'(dy_q) : W_UPD'(dx_q);
		dnew_c = dold_c - stepv_c;
		dsat_c = dnew_c;
		if (dnew_c > OFF_LIM)
			dsat_c = OFF_LIM;
		else if (dnew_c < -OFF_LIM)
			dsat_c = -OFF_LIM;
	end

	// loop decision after a step
	logic [W_TOL-1:0] tol_w;
	logic             more_c, outside_c;
	assign tol_w = {tol_q, FRAC_BITS'(0)};
	assign more_c = ($unsigned(g2_q) > 64'(tol_w))
		&& ((W_STEP+1)'(steps_q) + (W_STEP+1)'(1) < (W_STEP+1)'(MAX_STEPS));
	assign outside_c = (dx_q > ONE_Q) || (dx_q < -ONE_Q) || (dy_q > ONE_Q) || (dy_q < -ONE_Q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q    <= '0;
			fin_q   <= 1'b0;
			vld_s1  <= 1'b0;
			steps_q <= '0;
			dsel_q  <= 1'b0;
			dcnt_q  <= '0;
			tol_q   <= DATA_W'(1);
		end else begin
			if (cfg.valid)
				tol_q <= cfg.data;
			vld_s1 <= (state_q == S_RUN);
			case (state_q)
				S_IDLE: begin
					if (win.valid)
						state_q <= S_COEF;
				end
				S_COEF: begin
					pc_q    <= '0;
					fin_q   <= 1'b0;
					steps_q <= '0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					if (pc_q == (fin_q ? PC_FIN_LAST : PC_STEP_LAST))
						state_q <= S_WAIT;
					else
						pc_q <= pc_q + PC_W'(1);
				end
				S_WAIT: begin
					state_q <= fin_q ? S_FIN : S_CHK;
				end
				S_CHK: begin
					dsel_q  <= 1'b0;
					state_q <= (dmag < DET_MIN) ? S_OUT : S_DSET;
				end
				S_DSET: begin
					dcnt_q  <= '0;
					state_q <= ((66'(un_c)) >= (66'(ud_c) << 2)) ? S_DUPD : S_DIV;
				end
				S_DIV: begin
					if (dcnt_q == W_CNT'(W_QUO - 1))
						state_q <= S_DUPD;
					else
						dcnt_q <= dcnt_q + W_CNT'(1);
				end
				S_DUPD: begin
					if (!dsel_q) begin
						dsel_q  <= 1'b1;
						state_q <= S_DSET;
					end else begin
						steps_q <= steps_q + W_STEP'(1);
						if (more_c) begin
							pc_q    <= '0;
							state_q <= S_RUN;
						end else begin
							state_q <= S_RNG;
						end
					end
				end
				S_RNG: begin
					if (outside_c) begin
						state_q <= S_OUT;
					end else begin
						pc_q    <= PC_FIN_FIRST;
						fin_q   <= 1'b1;
						state_q <= S_RUN;
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		// capture request
		if (state_q == S_IDLE && win.valid) begin
			m_q[0] <= win.sample_nw;
			m_q[1] <= win.sample_n;
			m_q[2] <= win.sample_ne;
			m_q[3] <= win.sample_w;
			m_q[4] <= win.sample_c;
			m_q[5] <= win.sample_e;
			m_q[6] <= win.sample_sw;
			m_q[7] <= win.sample_s;
			m_q[8] <= win.sample_se;
			px_q   <= win.pos_x;
			py_q   <= win.pos_y;
		end
		if (state_q == S_COEF) begin
			for (int k = 0; k < 9; k++)
				c_q[k] <= c_n[k];
			dx_q <= '0;
			dy_q <= '0;
		end

		// multiplier pipeline
		op_s1   <= cur;
		prod_s1 <= prod_c;
		neg_s1  <= opa[63] ^ opb[63] ^ cur.neg;

		// writeback
		if (vld_s1) begin
			case (op_s1.wb)
				WB_FIRST, WB_ACC: acc_q <= sum;
				WB_STORE: begin
					case (op_s1.dest)
						DST_XY:   xy_q   <= W_MONO'(val);
						DST_XX:   xx_q   <= W_MONO'(val);
						DST_YY:   yy_q   <= W_MONO'(val);
						DST_XYY:  xyy_q  <= W_MONO'(val);
						DST_XXY:  xxy_q  <= W_MONO'(val);
						DST_XXYY: xxyy_q <= W_MONO'(val);
						default: ;
					endcase
				end
				WB_LASTQ: begin
					case (op_s1.dest)
						DST_H0:  h0_q <= qsum;
						DST_H1:  h1_q <= qsum;
						DST_H2:  h2_q <= qsum;
						DST_G0:  g0_q <= qsum;
						DST_G1:  g1_q <= qsum;
						DST_V:   v_q  <= qsum;
						default: ;
					endcase
				end
				WB_LASTR: begin
					case (op_s1.dest)
						DST_DET:  det_q  <= sum;
						DST_NUM0: num0_q <= sum;
						DST_NUM1: num1_q <= sum;
						DST_G2:   g2_q   <= sum;
						default: ;
					endcase
				end
				default: ;
			endcase
		end

		// divider
		if (state_q == S_DSET) begin
			rem_q  <= 66'(un_c);
			dvs_q  <= ud_c;
			quo_q  <= '0;
			dneg_q <= num_sel[63] ^ det_q[63];
			dsat_q <= (66'(un_c)) >= (66'(ud_c) << 2);
		end
		if (state_q == S_DIV) begin
			rem_q <= ge_c ? (rr_c - dt_c) : rr_c;
			quo_q <= {quo_q[W_QUO-2:0], ge_c};
		end
		if (state_q == S_DUPD) begin
			if (dsel_q)
				dy_q <= W_OFF'(dsat_c);
			else
				dx_q <= W_OFF'(dsat_c);
		end

		// result register
		if (state_q == S_CHK && dmag < DET_MIN) begin
			nx_q <= px_q;
			ny_q <= py_q;
			pk_q <= '0;
			st_q <= ST_SINGULAR;
		end
		if (state_q == S_RNG && outside_c) begin
			nx_q <= px_q;
			ny_q <= py_q;
			pk_q <= '0;
			st_q <= ST_OUTSIDE;
		end
		if (state_q == S_FIN) begin
			nx_q <= sat32(64'(px_q) + 64'(dx_q));
			ny_q <= sat32(64'(py_q) + 64'(dy_q));
			pk_q <= v_q;
			st_q <= ST_FOUND;
		end
	end

endmodule
